[src/mase_pkg.sv]
// Shared constants, codes and types of the matrix add / subtract / multiply engine.
// Used by the engine top level; no dependencies.
`default_nettype none

package mase_pkg;

    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 8;

    localparam int VAL_W     = 16;
    localparam int RES_W     = 35;
    localparam int POS_W     = 3;
    localparam int DIM_W     = 4;
    localparam int OP_W      = 2;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 4;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);
    localparam int ACC_W  = RES_W + CNT_W;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;

    localparam logic [MODE_W-1:0] MODE_WR_A    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_B    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

[src/mase_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module mase_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[src/matrix_add_sub_mul_engine_unit.sv]
// Matrix add / subtract / multiply engine: two element stores, sequencer and accumulator.
// Depends on mase_pkg and mase_ram.
// Load transactions: one per cycle while the engine is idle (o_in_stall low). Compute: each
// result element takes one store read (one per inner step for a product), then a two-stage
// multiply/accumulate drain. Synchronous active-low reset clears the stores through
// per-entry valid bits (instantly, no sweep) and sets operation to product, dims to 8.
`default_nettype none

module matrix_add_sub_mul_engine_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [mase_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [mase_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [mase_pkg::MODE_W-1:0]         i_mode,
    input  wire logic [mase_pkg::POS_W-1:0]          i_row,
    input  wire logic [mase_pkg::POS_W-1:0]          i_col,
    input  wire logic signed [mase_pkg::VAL_W-1:0]   i_value,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [mase_pkg::POS_W-1:0]               o_out_row,
    output logic [mase_pkg::POS_W-1:0]               o_out_col,
    output logic signed [mase_pkg::RES_W-1:0]        o_result,
    output logic                                     o_last
);

    import mase_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO =
        {{(ACC_W-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}};

    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
        if (int'(d) > MAX_DIM) begin
            return IDX_W'(MAX_DIM - 1);
        end else if (d == '0) begin
            return '0;
        end else begin
            return IDX_W'(d - DIM_W'(1));
        end
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
                                                  input logic [IDX_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
    endfunction

    t_state r_state, n_state;

    logic [OP_W-1:0]  r_cfg_op;
    logic [DIM_W-1:0] r_cfg_rows_a, r_cfg_cols_a, r_cfg_cols_b;

    logic [IDX_W-1:0] r_r, r_c, r_k, n_r, n_c, n_k;
    logic [DEPTH-1:0] r_vld_a, r_vld_b;

    logic                    r_rd_vld, r_msk_a, r_msk_b;
    logic                    r_term_vld;
    logic signed [ACC_W-1:0] r_term, r_acc;

    logic                    r_out_vld, r_out_last;
    logic [POS_W-1:0]        r_out_row, r_out_col;
    logic signed [RES_W-1:0] r_out_res;

    logic [IDX_W-1:0]  w_nr_last, w_ni_last, w_nc_last;
    logic              w_in_acc, w_start, w_issue, w_emit, w_out_free, w_pipe_idle;
    logic              w_k_done, w_elem_last, w_op_ok, w_wr_ok, w_we_a, w_we_b;
    logic [ADDR_W-1:0] w_waddr, w_addr_a, w_addr_b;
    logic [VAL_W-1:0]  w_q_a, w_q_b;
    logic signed [VAL_W-1:0]   w_a, w_b;
    logic signed [VAL_W:0]     w_sum;
    logic signed [2*VAL_W-1:0] w_prod;
    logic signed [ACC_W-1:0]   w_term, w_sat;

    mase_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_a (
        .i_clk  (i_clk),
        .i_we   (w_we_a),
        .i_waddr(w_waddr),
        .i_wdata(i_value),
        .i_raddr(w_addr_a),
        .o_rdata(w_q_a)
    );

    mase_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_store_b (
        .i_clk  (i_clk),
        .i_we   (w_we_b),
        .i_waddr(w_waddr),
        .i_wdata(i_value),
        .i_raddr(w_addr_b),
        .o_rdata(w_q_b)
    );

    always_comb begin
        w_nr_last = dim_last(r_cfg_rows_a);
        w_ni_last = dim_last(r_cfg_cols_a);
        w_nc_last = (r_cfg_op == OP_MUL) ? dim_last(r_cfg_cols_b) : w_ni_last;
        w_op_ok   = (r_cfg_op == OP_ADD) || (r_cfg_op == OP_SUB) || (r_cfg_op == OP_MUL);

        w_out_free  = !r_out_vld || !i_out_stall;
        w_pipe_idle = !r_rd_vld && !r_term_vld;
        w_k_done    = (r_cfg_op != OP_MUL) || (r_k == w_ni_last);
        w_elem_last = (r_r == w_nr_last) && (r_c == w_nc_last);

        w_waddr = addr_of(IDX_W'(i_row), IDX_W'(i_col));
        if (r_cfg_op == OP_MUL) begin
            w_addr_a = addr_of(r_r, r_k);
            w_addr_b = addr_of(r_k, r_c);
        end else begin
            w_addr_a = addr_of(r_r, r_c);
            w_addr_b = addr_of(r_r, r_c);
        end
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_stall = (r_state != ST_IDLE);
        w_in_acc   = i_in_valid && (r_state == ST_IDLE);
        w_start    = w_in_acc && (i_mode == MODE_COMPUTE) && w_op_ok;
        w_issue    = (r_state == ST_READ);
        w_emit     = (r_state == ST_DRAIN) && w_pipe_idle && w_out_free;
        w_wr_ok    = w_in_acc && (int'(i_row) < MAX_DIM) && (int'(i_col) < MAX_DIM);
        w_we_a     = w_wr_ok && (i_mode == MODE_WR_A);
        w_we_b     = w_wr_ok && (i_mode == MODE_WR_B);

        n_r = r_r;
        n_c = r_c;
        n_k = r_k;
        if (w_start) begin
            n_r = '0;
            n_c = '0;
            n_k = '0;
        end else if (w_issue && !w_k_done) begin
            n_k = r_k + IDX_W'(1);
        end else if (w_emit) begin
            n_k = '0;
            if (r_c == w_nc_last) begin
                n_c = '0;
                n_r = r_r + IDX_W'(1);
            end else begin
                n_c = r_c + IDX_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (w_k_done) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_emit) begin
                    n_state = w_elem_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Term formation: masked store data, then scaled sum/difference or product
    always_comb begin
        w_a    = r_msk_a ? signed'(w_q_a) : '0;
        w_b    = r_msk_b ? signed'(w_q_b) : '0;
        w_sum  = (r_cfg_op == OP_SUB) ? ((VAL_W+1)'(w_a) - (VAL_W+1)'(w_b))
                                      : ((VAL_W+1)'(w_a) + (VAL_W+1)'(w_b));
        w_prod = (2*VAL_W)'(w_a) * (2*VAL_W)'(w_b);
        if (r_cfg_op == OP_MUL) begin
            w_term = ACC_W'(w_prod);
        end else begin
            w_term = ACC_W'(w_sum) <<< FRAC_BITS;
        end

        if (r_acc > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (r_acc < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_op     <= OP_MUL;
            r_cfg_rows_a <= DIM_W'(8);
            r_cfg_cols_a <= DIM_W'(8);
            r_cfg_cols_b <= DIM_W'(8);
            r_vld_a      <= '0;
            r_vld_b      <= '0;
            r_rd_vld     <= 1'b0;
            r_term_vld   <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= w_issue;
            r_term_vld <= r_rd_vld;

            if (w_we_a) begin
                r_vld_a[w_waddr] <= 1'b1;
            end
            if (w_we_b) begin
                r_vld_b[w_waddr] <= 1'b1;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OPERATION: r_cfg_op     <= i_cfg_data[OP_W-1:0];
                    CFG_ROWS_A:    r_cfg_rows_a <= i_cfg_data[DIM_W-1:0];
                    CFG_COLS_A:    r_cfg_cols_a <= i_cfg_data[DIM_W-1:0];
                    CFG_COLS_B:    r_cfg_cols_b <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end

            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_r     <= n_r;
        r_c     <= n_c;
        r_k     <= n_k;
        r_msk_a <= r_vld_a[w_addr_a];
        r_msk_b <= r_vld_b[w_addr_b];
        r_term  <= w_term;

        if (w_start || w_emit) begin
            r_acc <= '0;
        end else if (r_term_vld) begin
            r_acc <= r_acc + r_term;
        end

        if (w_emit) begin
            r_out_row  <= POS_W'(r_r);
            r_out_col  <= POS_W'(r_c);
            r_out_res  <= RES_W'(w_sat);
            r_out_last <= w_elem_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_result    = r_out_res;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

[verif/mase_tb_pkg.sv]
`timescale 1ns / 1ps
// Expected-result tracker for the matrix add / subtract / multiply engine testbench.
// Depends on mase_pkg for field widths, operation, mode and register codes.
package mase_tb_pkg;

    import mase_pkg::*;

    localparam longint RES_HI = (longint'(1) <<< (RES_W - 1)) - 1;
    localparam longint RES_LO = -(longint'(1) <<< (RES_W - 1));

    typedef struct {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [RES_W-1:0] value;
        logic                    last;
    } t_elem;

    function automatic int unsigned fit_dim(logic [DIM_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return d;
    endfunction

    class matrix_result_tracker;
        logic signed [VAL_W-1:0] mat_a [DEPTH];
        logic signed [VAL_W-1:0] mat_b [DEPTH];
        logic [OP_W-1:0]         cur_op;
        logic [DIM_W-1:0]        n_rows;
        logic [DIM_W-1:0]        n_inner;
        logic [DIM_W-1:0]        n_cols_b;
        t_elem                   pending_elems[$];
        int                      mismatches;

        function new();
            foreach (mat_a[i]) begin
                mat_a[i] = '0;
                mat_b[i] = '0;
            end
            cur_op     = OP_MUL;
            n_rows     = DIM_W'(MAX_DIM);
            n_inner    = DIM_W'(MAX_DIM);
            n_cols_b   = DIM_W'(MAX_DIM);
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_OPERATION: cur_op   = data[OP_W-1:0];
                CFG_ROWS_A:    n_rows   = data[DIM_W-1:0];
                CFG_COLS_A:    n_inner  = data[DIM_W-1:0];
                CFG_COLS_B:    n_cols_b = data[DIM_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(logic [MODE_W-1:0] mode, logic [POS_W-1:0] row,
                                logic [POS_W-1:0] col, logic signed [VAL_W-1:0] value);
            int unsigned nr;
            int unsigned ni;
            int unsigned nc;
            longint      acc;
            longint      ea;
            longint      eb;
            t_elem       e;
            if (mode == MODE_WR_A) begin
                mat_a[int'(row) * MAX_DIM + int'(col)] = value;
                return;
            end
            if (mode == MODE_WR_B) begin
                mat_b[int'(row) * MAX_DIM + int'(col)] = value;
                return;
            end
            if (mode != MODE_COMPUTE || cur_op > OP_MUL) return;
            nr = fit_dim(n_rows);
            ni = fit_dim(n_inner);
            nc = (cur_op == OP_MUL) ? fit_dim(n_cols_b) : ni;
            for (int r = 0; r < nr; r++) begin
                for (int c = 0; c < nc; c++) begin
                    acc = 0;
                    if (cur_op == OP_MUL) begin
                        for (int k = 0; k < ni; k++) begin
                            ea = longint'(mat_a[r * MAX_DIM + k]);
                            eb = longint'(mat_b[k * MAX_DIM + c]);
                            acc += ea * eb;
                        end
                    end else begin
                        ea = longint'(mat_a[r * MAX_DIM + c]);
                        eb = longint'(mat_b[r * MAX_DIM + c]);
                        acc = (cur_op == OP_ADD) ? ea + eb : ea - eb;
                        acc = acc * (longint'(1) <<< FRAC_BITS);
                    end
                    if (acc > RES_HI) acc = RES_HI;
                    if (acc < RES_LO) acc = RES_LO;
                    e.row   = POS_W'(r);
                    e.col   = POS_W'(c);
                    e.value = RES_W'(acc);
                    e.last  = (r == nr - 1) && (c == nc - 1);
                    pending_elems.insert(pending_elems.size(), e);
                end
            end
        endfunction

        function void check_element(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                    logic signed [RES_W-1:0] value, logic last);
            t_elem e;
            if (pending_elems.size() == 0) begin
                $error("result row %0d col %0d arrived with none expected", row, col);
                mismatches++;
                return;
            end
            e = pending_elems.pop_front();
            if (row !== e.row) begin
                $error("out_row: expected %0d, actual %0d", e.row, row);
                mismatches++;
            end
            if (col !== e.col) begin
                $error("out_col: expected %0d, actual %0d", e.col, col);
                mismatches++;
            end
            if (value !== e.value) begin
                $error("result: expected %0d, actual %0d", e.value, value);
                mismatches++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, actual %0d", e.last, last);
                mismatches++;
            end
        endfunction
    endclass

endpackage

[verif/tb.sv]
`timescale 1ns / 1ps
// Top-level testbench for matrix_add_sub_mul_engine_unit: directed loads and computes,
// then random load/compute sequences under varying idle and stall pressure.
// Depends on mase_pkg and mase_tb_pkg.
module tb;

    import mase_pkg::*;
    import mase_tb_pkg::*;

    localparam longint LIMIT_CYCLES  = 1000000;
    localparam int     SETTLE_CYCLES = 32;
    localparam int     HOLD_LEN      = 400;
    localparam int     RANDOM_ITEMS  = 300;

    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    localparam logic [OP_W-1:0]   OP_NONE   = 2'd3;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data  = '0;
    logic                    i_in_valid  = 1'b0;
    logic [MODE_W-1:0]       i_mode      = '0;
    logic [POS_W-1:0]        i_row       = '0;
    logic [POS_W-1:0]        i_col       = '0;
    logic signed [VAL_W-1:0] i_value     = '0;
    logic                    i_out_stall = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [POS_W-1:0]        o_out_row;
    logic [POS_W-1:0]        o_out_col;
    logic signed [RES_W-1:0] o_result;
    logic                    o_last;

    matrix_result_tracker board;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    bit     long_hold      = 1'b0;
    int     hold_count     = 0;
    int     random_items   = 0;
    longint cycle_count    = 0;

    matrix_add_sub_mul_engine_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_result    (o_result),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_element(o_out_row, o_out_col, o_result, o_last);
    end

    // hold off once for a long stretch, otherwise stall at random
    always @(negedge i_clk) begin
        if (long_hold && hold_count < HOLD_LEN) begin
            i_out_stall = 1'b1;
            hold_count++;
        end else begin
            i_out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        if ($urandom_range(5) == 0) return DIM_W'($urandom_range(15));
        return DIM_W'($urandom_range(4, 1));
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] row,
                             input logic [POS_W-1:0] col, input logic signed [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_mode     = mode;
        i_row      = row;
        i_col      = col;
        i_value    = value;
        do @(posedge i_clk); while (o_in_stall);
        board.note_item(mode, row, col, value);
    endtask

    task automatic send_counted(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] row,
                                input logic [POS_W-1:0] col,
                                input logic signed [VAL_W-1:0] value);
        send_item(mode, row, col, value);
        if (mode != MODE_NONE) random_items++;
    endtask

    task automatic send_noise();
        send_counted(MODE_W'($urandom_range(3)), POS_W'($urandom_range(7)),
                     POS_W'($urandom_range(7)), pick_value());
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.pending_elems.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] op_data, input logic [DIM_W-1:0] rows,
                                input logic [DIM_W-1:0] inner, input logic [DIM_W-1:0] cols);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     vals [4];
        idx  = '{CFG_OPERATION, CFG_ROWS_A, CFG_COLS_A, CFG_COLS_B};
        vals = '{op_data, rows, inner, cols};
        drain_results();
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we    = 1'b1;
            i_cfg_index = idx[i];
            i_cfg_data  = vals[i];
            @(posedge i_clk);
            board.write_reg(idx[i], vals[i]);
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic load_and_compute();
        int unsigned nr;
        int unsigned ni;
        int unsigned nc;
        int unsigned br;
        nr = fit_dim(board.n_rows);
        ni = fit_dim(board.n_inner);
        nc = (board.cur_op == OP_MUL) ? fit_dim(board.n_cols_b) : ni;
        br = (board.cur_op == OP_MUL) ? ni : nr;
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < ni; c++) begin
                if ($urandom_range(9) == 0) send_noise();
                send_counted(MODE_WR_A, POS_W'(r), POS_W'(c), pick_value());
            end
        end
        for (int r = 0; r < br; r++) begin
            for (int c = 0; c < nc; c++) begin
                if ($urandom_range(9) == 0) send_noise();
                send_counted(MODE_WR_B, POS_W'(r), POS_W'(c), pick_value());
            end
        end
        send_counted(MODE_COMPUTE, POS_W'($urandom_range(7)), POS_W'($urandom_range(7)),
                     pick_value());
    endtask

    initial begin
        logic [OP_W-1:0] op;
        int              ph;
        board = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(MODE_WR_A, 3'd0, 3'd0, 16'sh7FFF);
        send_item(MODE_WR_B, 3'd0, 3'd0, 16'sh7FFF);
        send_item(MODE_WR_A, 3'd0, 3'd1, 16'sh8000);
        send_item(MODE_WR_B, 3'd1, 3'd0, 16'sh8000);
        send_item(MODE_WR_A, 3'd7, 3'd7, 16'sh8000);
        send_item(MODE_WR_B, 3'd7, 3'd7, 16'sh8000);
        send_item(MODE_WR_A, 3'd3, 3'd5, 16'sh5A5A);
        send_item(MODE_WR_B, 3'd5, 3'd2, -16'sd1);
        send_item(MODE_NONE, 3'd7, 3'd7, 16'sh7FFF);
        send_item(MODE_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        write_config(CFG_W'(OP_ADD), 4'd8, 4'd8, 4'd8);
        send_item(MODE_COMPUTE, 3'd7, 3'd7, 16'shFFFF);
        write_config(CFG_W'(OP_SUB), 4'd8, 4'd8, 4'd8);
        send_item(MODE_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        write_config(CFG_W'(OP_NONE), 4'd8, 4'd8, 4'd8);
        send_item(MODE_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        write_config(CFG_W'(OP_MUL), 4'd0, 4'd0, 4'd0);
        send_item(MODE_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        write_config({2'b11, OP_MUL}, 4'd15, 4'd9, 4'd12);
        send_item(MODE_COMPUTE, 3'd0, 3'd0, 16'sh0000);
        write_config(CFG_W'(OP_ADD), 4'd1, 4'd8, 4'd0);
        send_item(MODE_COMPUTE, 3'd0, 3'd0, 16'sh0000);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            while (random_items < (ph + 1) * RANDOM_ITEMS / 4) begin
                op = ($urandom_range(9) == 0) ? OP_NONE : OP_W'($urandom_range(OP_MUL));
                if (ph == 2) op = OP_MUL;
                write_config({2'($urandom_range(3)), op}, pick_dim(), pick_dim(), pick_dim());
                if (ph == 2) long_hold = 1'b1;
                repeat (2) load_and_compute();
            end
        end

        drain_results();
        if (board.mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

[files.f]
src/mase_pkg.sv
src/mase_ram.sv
src/matrix_add_sub_mul_engine_unit.sv
verif/mase_tb_pkg.sv
verif/tb.sv
